// ===== src/lic_pkg.sv =====
// Shared types, constants and command codes for the level interrupt controller.
// Used by lic_front, lic_cmd_fifo, lic_back and level_interrupt_controller_core.
package lic_pkg;

  localparam int IRQ_LINES  = 64;
  localparam int LINE_SLOTS = 64;
  localparam int LINE_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int GROUP_W    = 8;
  localparam int GROUPS     = LINE_SLOTS / GROUP_W;
  localparam int GROUP_IW   = 3;
  localparam int BIT_IW     = 3;
  localparam int FIFO_DEPTH = 2;

  localparam logic [31:0] ID_VALUE     = 32'hC51D_0000;
  localparam logic [31:0] NONE_PENDING = 32'hFFFF_FFFF;

  localparam logic [1:0] MODE_LINE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_WRITE = 2'd2;

  localparam logic [9:0] WORD_ID      = 10'd0;
  localparam logic [9:0] WORD_COUNT   = 10'd1;
  localparam logic [9:0] WORD_LOWEST  = 10'd2;
  localparam logic [9:0] WORD_DIS_ALL = 10'd3;
  localparam logic [9:0] WORD_DIS     = 10'd4;
  localparam logic [9:0] WORD_EN      = 10'd5;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LINE,
    OP_RD_ID,
    OP_RD_COUNT,
    OP_RD_LOWEST,
    OP_DIS_ALL,
    OP_DIS,
    OP_EN,
    OP_BAD
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [LINE_W-1:0] line;
    logic              level;
    logic              line_ok;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } bk_state_t;

endpackage

// ===== src/level_interrupt_controller_core.sv =====
// Top level of the level interrupt controller: front decode, command queue, back end.
// Depends on lic_pkg, lic_front, lic_cmd_fifo and lic_back.
//
// Usage. Every request on the in_ channel carries either a line level change
// (in_mode line), a bus read or a bus write, and yields exactly one result on
// the out_ channel: read data, the parent interrupt level after the request,
// and a flag for an access to an unsupported register word.
// A request is decoded on entry and placed in a two-entry queue; the back end
// takes it from there and loads the registered result. A read of the lowest
// active line searches the 64 lines in two registered steps (group of eight,
// then line within the group). Sustained throughput is one request a cycle
// while the receiver does not stall; the back end takes no new request while
// a lowest-line read is in its scan state.
// When the receiver stalls, the result stays in the output register and the
// queue goes on taking requests until both its entries are full; in_ready
// then drops. After reset every line is low and disabled, the pending count
// is zero and both the queue and the output register are empty.
module level_interrupt_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [5:0]  in_line_index,
  input  logic        in_line_level,
  input  logic [11:0] in_byte_offset,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_irq,
  output logic        out_bad_access
);

  lic_pkg::cmd_t dec_cmd;
  lic_pkg::cmd_t head_cmd;
  logic          fifo_full;
  logic          head_valid;
  logic          head_pop;

  // The queue accepts a request whenever it has a free entry.
  assign in_ready = !fifo_full;

  lic_front u_front (
    .in_mode        (in_mode),
    .in_line_index  (in_line_index),
    .in_line_level  (in_line_level),
    .in_byte_offset (in_byte_offset),
    .in_write_data  (in_write_data),
    .cmd            (dec_cmd)
  );

  lic_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid && in_ready),
    .push_cmd   (dec_cmd),
    .full       (fifo_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  lic_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (head_valid),
    .cmd            (head_cmd),
    .cmd_pop        (head_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_irq        (out_irq),
    .out_bad_access (out_bad_access)
  );

endmodule

// ===== src/lic_front.sv =====
// Front end: decodes an incoming request into a command for the queue.
// Depends on lic_pkg for the command type and the word map.
module lic_front (
  input  logic [1:0]          in_mode,
  input  logic [5:0]          in_line_index,
  input  logic                in_line_level,
  input  logic [11:0]         in_byte_offset,
  input  logic [31:0]         in_write_data,
  output lic_pkg::cmd_t       cmd
);

  logic [9:0] word;

  assign word = in_byte_offset[11:2];

  always_comb begin
    cmd.op      = lic_pkg::OP_NOP;
    cmd.line    = in_line_index;
    cmd.level   = in_line_level;
    cmd.line_ok = 1'b0;
    unique case (in_mode)
      lic_pkg::MODE_LINE: begin
        cmd.op      = lic_pkg::OP_LINE;
        cmd.line_ok = {1'b0, in_line_index} < 7'(lic_pkg::IRQ_LINES);
      end
      lic_pkg::MODE_READ: begin
        unique case (word)
          lic_pkg::WORD_ID:     cmd.op = lic_pkg::OP_RD_ID;
          lic_pkg::WORD_COUNT:  cmd.op = lic_pkg::OP_RD_COUNT;
          lic_pkg::WORD_LOWEST: cmd.op = lic_pkg::OP_RD_LOWEST;
          default:              cmd.op = lic_pkg::OP_BAD;
        endcase
      end
      lic_pkg::MODE_WRITE: begin
        cmd.line    = in_write_data[lic_pkg::LINE_W-1:0];
        cmd.line_ok = in_write_data < 32'(lic_pkg::IRQ_LINES);
        unique case (word)
          lic_pkg::WORD_DIS_ALL: cmd.op = lic_pkg::OP_DIS_ALL;
          lic_pkg::WORD_DIS:     cmd.op = lic_pkg::OP_DIS;
          lic_pkg::WORD_EN:      cmd.op = lic_pkg::OP_EN;
          default:               cmd.op = lic_pkg::OP_BAD;
        endcase
      end
      default: cmd.op = lic_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== src/lic_cmd_fifo.sv =====
// Two-entry command queue between the decode front end and the execution back end.
// Depends on lic_pkg for the command type and the queue depth.
module lic_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lic_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output lic_pkg::cmd_t head_cmd
);

  lic_pkg::cmd_t mem_r [lic_pkg::FIFO_DEPTH];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full       = count_r == 2'(lic_pkg::FIFO_DEPTH);
  assign head_valid = count_r != 2'd0;
  assign head_cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== src/lic_back.sv =====
// Back end: holds the line levels, enables and pending count, executes commands
// and fills the result register. Depends on lic_pkg.
module lic_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  lic_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_read_data,
  output logic          out_irq,
  output logic          out_bad_access
);

  logic [lic_pkg::LINE_SLOTS-1:0] levels_r, levels_nxt;
  logic [lic_pkg::LINE_SLOTS-1:0] enables_r, enables_nxt;
  logic [lic_pkg::COUNT_W-1:0]    count_r, count_nxt;
  lic_pkg::bk_state_t             state_r, state_nxt;

  logic                           valid_r, valid_nxt;
  logic [31:0]                    rdata_r, rdata_nxt;
  logic                           irq_r, irq_nxt;
  logic                           bad_r, bad_nxt;

  // First scan stage result: lowest non-empty group of active lines.
  logic                           any_r, any_nxt;
  logic [lic_pkg::GROUP_IW-1:0]   grp_r, grp_nxt;
  logic [lic_pkg::GROUP_W-1:0]    bits_r, bits_nxt;

  logic [lic_pkg::LINE_SLOTS-1:0] active;
  logic [lic_pkg::BIT_IW-1:0]     low_bit;
  logic                           slot_free;

  assign active    = levels_r & enables_r;
  assign slot_free = !valid_r || out_ready;

  assign out_valid      = valid_r;
  assign out_read_data  = rdata_r;
  assign out_irq        = irq_r;
  assign out_bad_access = bad_r;

  always_comb begin
    any_nxt  = 1'b0;
    grp_nxt  = '0;
    bits_nxt = active[lic_pkg::GROUP_W-1:0];
    for (int g = lic_pkg::GROUPS - 1; g >= 0; g--) begin
      if (|active[g*lic_pkg::GROUP_W +: lic_pkg::GROUP_W]) begin
        any_nxt  = 1'b1;
        grp_nxt  = lic_pkg::GROUP_IW'(g);
        bits_nxt = active[g*lic_pkg::GROUP_W +: lic_pkg::GROUP_W];
      end
    end
  end

  always_comb begin
    low_bit = '0;
    for (int b = lic_pkg::GROUP_W - 1; b >= 0; b--) begin
      if (bits_r[b]) begin
        low_bit = lic_pkg::BIT_IW'(b);
      end
    end
  end

  always_comb begin
    levels_nxt  = levels_r;
    enables_nxt = enables_r;
    count_nxt   = count_r;
    state_nxt   = state_r;
    valid_nxt   = valid_r && !out_ready;
    rdata_nxt   = rdata_r;
    irq_nxt     = irq_r;
    bad_nxt     = bad_r;
    cmd_pop     = 1'b0;
    unique case (state_r)
      lic_pkg::BK_IDLE: begin
        if (cmd_valid && slot_free) begin
          cmd_pop   = 1'b1;
          valid_nxt = 1'b1;
          rdata_nxt = '0;
          bad_nxt   = 1'b0;
          case (cmd.op)
            lic_pkg::OP_LINE: begin
              if (cmd.line_ok && levels_r[cmd.line] != cmd.level) begin
                levels_nxt[cmd.line] = cmd.level;
                if (enables_r[cmd.line]) begin
                  count_nxt = cmd.level ? count_r + lic_pkg::COUNT_W'(1)
                                        : count_r - lic_pkg::COUNT_W'(1);
                end
              end
            end
            lic_pkg::OP_RD_ID:    rdata_nxt = lic_pkg::ID_VALUE;
            lic_pkg::OP_RD_COUNT: rdata_nxt = 32'(count_r);
            lic_pkg::OP_RD_LOWEST: begin
              valid_nxt = 1'b0;
              state_nxt = lic_pkg::BK_SCAN;
            end
            lic_pkg::OP_DIS_ALL: begin
              enables_nxt = '0;
              count_nxt   = '0;
            end
            lic_pkg::OP_DIS: begin
              if (cmd.line_ok && enables_r[cmd.line]) begin
                enables_nxt[cmd.line] = 1'b0;
                if (levels_r[cmd.line]) begin
                  count_nxt = count_r - lic_pkg::COUNT_W'(1);
                end
              end
            end
            lic_pkg::OP_EN: begin
              if (cmd.line_ok && !enables_r[cmd.line]) begin
                enables_nxt[cmd.line] = 1'b1;
                if (levels_r[cmd.line]) begin
                  count_nxt = count_r + lic_pkg::COUNT_W'(1);
                end
              end
            end
            lic_pkg::OP_BAD: bad_nxt = 1'b1;
            default: ;
          endcase
          irq_nxt = count_nxt != '0;
        end
      end
      lic_pkg::BK_SCAN: begin
        if (slot_free) begin
          valid_nxt = 1'b1;
          bad_nxt   = 1'b0;
          irq_nxt   = count_r != '0;
          rdata_nxt = any_r ? 32'({grp_r, low_bit}) : lic_pkg::NONE_PENDING;
          state_nxt = lic_pkg::BK_IDLE;
        end
      end
      default: state_nxt = lic_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      levels_r  <= '0;
      enables_r <= '0;
      count_r   <= '0;
      state_r   <= lic_pkg::BK_IDLE;
      valid_r   <= 1'b0;
    end else begin
      levels_r  <= levels_nxt;
      enables_r <= enables_nxt;
      count_r   <= count_nxt;
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= rdata_nxt;
    irq_r   <= irq_nxt;
    bad_r   <= bad_nxt;
    if (state_r == lic_pkg::BK_IDLE) begin
      any_r  <= any_nxt;
      grp_r  <= grp_nxt;
      bits_r <= bits_nxt;
    end
  end

endmodule
